// File: sv/tie_pkg.sv
// Shared types and constants for the toy ISA instruction executor.
`default_nettype none

package tie_pkg;

	// Defaults for the top-level parameters
	localparam int MEM_DEPTH_DEF  = 256;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int PC_WIDTH_DEF   = 16;

	// Register file shape (fixed by the 4-bit register fields)
	localparam int REG_COUNT = 16;
	localparam int REG_AW    = 4;

	// Stream payload layout
	localparam int S_USER_W    = 2;
	localparam int S_DATA_W    = 56;
	localparam int M_DATA_W    = 56;
	localparam int M_HALT_BIT  = 16;
	localparam int M_TAKEN_BIT = 17;
	localparam int M_RDATA_LSB = 18;
	localparam int M_BAD_BIT   = 50;

	// Command carried in tuser
	typedef enum logic [1:0] {
		CMD_EXEC   = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_READ   = 2'd2,
		CMD_IGNORE = 2'd3
	} cmd_t;

	// Instruction opcode, bits 15:13
	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_MUL   = 3'd2,
		OP_LOAD  = 3'd3,
		OP_STORE = 3'd4,
		OP_JUMP  = 3'd5,
		OP_BEQZ  = 3'd6,
		OP_SYS   = 3'd7
	} op_t;

	// Classified item passed from the front end to the back end
	typedef struct packed {
		cmd_t                cmd;
		op_t                 op;
		logic                imm;
		logic [REG_AW-1:0]   rd;
		logic [REG_AW-1:0]   rs;
		logic [REG_AW-1:0]   rt;
		logic [15:0]         instr;
		logic [7:0]          maddr;
		logic [31:0]         wdata;
	} item_t;

	// Result fields of one item
	typedef struct packed {
		logic        bad_address;
		logic [31:0] read_data;
		logic        branch_taken;
		logic        halted;
		logic [15:0] next_pc;
	} result_t;

endpackage

`default_nettype wire

// File: sv/tie_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module tie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, or read into the output register; hold otherwise
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/tie_front.sv
// Front end: accept items, classify them and queue them for the back end.
`default_nettype none

module tie_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [tie_pkg::S_USER_W-1:0]  s_tuser,
	input  wire logic [tie_pkg::S_DATA_W-1:0]  s_tdata,
	input  wire logic                          clearing,
	output logic                               q_valid,
	output tie_pkg::item_t                     q_item,
	input  wire logic                          q_pop
);

	tie_pkg::item_t in_item;
	tie_pkg::item_t slot_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           push;

	// Classify the incoming item
	always_comb begin
		in_item.cmd   = tie_pkg::cmd_t'(s_tuser);
		in_item.instr = s_tdata[15:0];
		in_item.op    = tie_pkg::op_t'(s_tdata[15:13]);
		in_item.imm   = s_tdata[12];
		in_item.rd    = s_tdata[11:8];
		in_item.rs    = s_tdata[7:4];
		in_item.rt    = s_tdata[3:0];
		in_item.maddr = s_tdata[23:16];
		in_item.wdata = s_tdata[55:24];
	end

	// Two-entry queue towards the back end
	assign s_tready = (cnt_q != 2'd2) && !clearing;
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (q_pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Store the classified item
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= in_item;
		end
	end

endmodule

`default_nettype wire

// File: sv/tie_back.sv
// Back end: execute queued items against pc, registers and data memory.
`default_nettype none

module tie_back #(
	parameter int MEM_DEPTH  = tie_pkg::MEM_DEPTH_DEF,
	parameter int DATA_WIDTH = tie_pkg::DATA_WIDTH_DEF,
	parameter int PC_WIDTH   = tie_pkg::PC_WIDTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  tie_pkg::item_t       q_item,
	output logic                 q_pop,
	output logic                 clearing,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output tie_pkg::result_t     res
);

	localparam int AW   = $clog2(MEM_DEPTH);
	localparam int CMPW = DATA_WIDTH + 18;

	// Architectural state
	logic [DATA_WIDTH-1:0] rf_q [tie_pkg::REG_COUNT];
	logic [PC_WIDTH-1:0]   pc_q;
	logic                  halt_q;

	// Memory clearing pass
	logic                  clr_busy_q;
	logic [AW-1:0]         clr_addr_q;

	// Result stage
	logic                  s2_valid_q;
	logic [PC_WIDTH-1:0]   pc_s2;
	logic                  halt_s2;
	logic                  taken_s2;
	logic                  bad_s2;
	logic                  rdsel_s2;
	logic                  wb_s2;
	logic [tie_pkg::REG_AW-1:0] wb_rd_s2;
	logic                  wb_bad_s2;

	// Execute signals
	tie_pkg::item_t        ex;
	logic                  go;
	logic                  run;
	logic [DATA_WIDTH-1:0] load_val;
	logic [DATA_WIDTH-1:0] va;
	logic [DATA_WIDTH-1:0] vt;
	logic [DATA_WIDTH-1:0] vd;
	logic [DATA_WIDTH-1:0] opb;
	logic [PC_WIDTH-1:0]   off_j;
	logic [PC_WIDTH-1:0]   off_b;
	logic                  a_ok;
	logic                  d_ok;
	logic                  m_ok;
	logic [PC_WIDTH-1:0]   pc_nx;
	logic                  halt_nx;
	logic                  taken;
	logic                  bad;
	logic                  rdsel;
	logic                  rf_we;
	logic [DATA_WIDTH-1:0] rf_wd;
	logic                  ld;
	logic                  ld_bad;
	logic                  ram_en;
	logic                  ram_we;
	logic [AW-1:0]         ram_addr;
	logic [DATA_WIDTH-1:0] ram_wd;
	logic [DATA_WIDTH-1:0] ram_rd;

	assign ex       = q_item;
	assign go       = q_valid && (!s2_valid_q || m_tready) && !clr_busy_q;
	assign q_pop    = go;
	assign clearing = clr_busy_q;
	assign run      = (ex.cmd == tie_pkg::CMD_EXEC) && !halt_q;

	// Forward a load that writes back this cycle
	assign load_val = wb_bad_s2 ? '0 : ram_rd;
	assign va = (wb_s2 && wb_rd_s2 == ex.rs) ? load_val : rf_q[ex.rs];
	assign vt = (wb_s2 && wb_rd_s2 == ex.rt) ? load_val : rf_q[ex.rt];
	assign vd = (wb_s2 && wb_rd_s2 == ex.rd) ? load_val : rf_q[ex.rd];

	assign opb   = ex.imm ? DATA_WIDTH'($signed(ex.instr[3:0])) : vt;
	assign off_j = PC_WIDTH'($signed(ex.instr[11:4]));
	assign off_b = PC_WIDTH'($signed(ex.instr[7:0]));
	assign a_ok  = CMPW'(va) < CMPW'(MEM_DEPTH);
	assign d_ok  = CMPW'(vd) < CMPW'(MEM_DEPTH);
	assign m_ok  = CMPW'(ex.maddr) < CMPW'(MEM_DEPTH);

	// Execute one item
	always_comb begin
		pc_nx    = pc_q;
		halt_nx  = halt_q;
		taken    = 1'b0;
		bad      = 1'b0;
		rdsel    = 1'b0;
		rf_we    = 1'b0;
		rf_wd    = '0;
		ld       = 1'b0;
		ld_bad   = 1'b0;
		ram_en   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = AW'(ex.maddr);
		ram_wd   = DATA_WIDTH'($signed(ex.wdata));
		unique case (ex.cmd)
			tie_pkg::CMD_WRITE: begin
				ram_en = m_ok;
				ram_we = m_ok;
				bad    = !m_ok;
			end
			tie_pkg::CMD_READ: begin
				ram_en = m_ok;
				rdsel  = m_ok;
				bad    = !m_ok;
			end
			tie_pkg::CMD_EXEC: begin
				if (run) begin
					pc_nx = pc_q + PC_WIDTH'(2);
					unique case (ex.op)
						tie_pkg::OP_ADD: begin
							rf_we = 1'b1;
							rf_wd = va + opb;
						end
						tie_pkg::OP_SUB: begin
							rf_we = 1'b1;
							rf_wd = va - opb;
						end
						tie_pkg::OP_MUL: begin
							rf_we = 1'b1;
							rf_wd = va * opb;
						end
						tie_pkg::OP_LOAD: begin
							ld       = 1'b1;
							ld_bad   = !a_ok;
							bad      = !a_ok;
							ram_en   = a_ok;
							ram_addr = AW'(va);
						end
						tie_pkg::OP_STORE: begin
							bad      = !d_ok;
							ram_en   = d_ok;
							ram_we   = d_ok;
							ram_addr = AW'(vd);
							ram_wd   = va;
						end
						tie_pkg::OP_JUMP: begin
							pc_nx = pc_q + (off_j << 1);
							taken = 1'b1;
						end
						tie_pkg::OP_BEQZ: begin
							if (vd == '0) begin
								pc_nx = pc_q + (off_b << 1);
								taken = 1'b1;
							end
						end
						tie_pkg::OP_SYS: begin
							if (!ex.imm) begin
								halt_nx = 1'b1;
								pc_nx   = pc_q;
							end
						end
						default: begin
						end
					endcase
				end
			end
			tie_pkg::CMD_IGNORE: begin
			end
			default: begin
			end
		endcase
		// Clearing pass owns the memory port
		if (clr_busy_q) begin
			ram_en   = 1'b1;
			ram_we   = 1'b1;
			ram_addr = clr_addr_q;
			ram_wd   = '0;
		end else if (!go) begin
			ram_en = 1'b0;
		end
	end

	tie_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wd),
		.rdata (ram_rd)
	);

	// Control state: pc, halt, clearing pass, result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= '0;
			halt_q     <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			s2_valid_q <= 1'b0;
			wb_s2      <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(MEM_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (go) begin
				pc_q       <= pc_nx;
				halt_q     <= halt_nx;
				s2_valid_q <= 1'b1;
			end else if (m_tready) begin
				s2_valid_q <= 1'b0;
			end
			wb_s2 <= go && ld;
		end
	end

	// Result payload and load write-back tag
	always_ff @(posedge clk) begin
		if (go) begin
			pc_s2     <= pc_nx;
			halt_s2   <= halt_nx;
			taken_s2  <= taken;
			bad_s2    <= bad;
			rdsel_s2  <= rdsel;
			wb_rd_s2  <= ex.rd;
			wb_bad_s2 <= ld_bad;
		end
	end

	// Register file: drop the load write-back when a later ALU write takes the same register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tie_pkg::REG_COUNT; i++) begin
				rf_q[i] <= '0;
			end
		end else begin
			if (wb_s2 && !(go && rf_we && ex.rd == wb_rd_s2)) begin
				rf_q[wb_rd_s2] <= load_val;
			end
			if (go && rf_we) begin
				rf_q[ex.rd] <= rf_wd;
			end
		end
	end

	assign m_tvalid         = s2_valid_q;
	assign res.next_pc      = 16'(pc_s2);
	assign res.halted       = halt_s2;
	assign res.branch_taken = taken_s2;
	assign res.read_data    = rdsel_s2 ? 32'(ram_rd) : 32'd0;
	assign res.bad_address  = bad_s2;

endmodule

`default_nettype wire

// File: sv/toy_isa_instruction_executor_core.sv
// Top level of the toy ISA instruction executor.
//
// channel | dir | handshake         | payload
// s       | in  | s_tvalid/s_tready | tuser: command; tdata: instruction, mem_address, write_data
// m       | out | m_tvalid/m_tready | tdata: next_pc, halted, branch_taken, read_data, bad_address
//
// One item per cycle is sustained while m accepts results; each result is
// registered and appears in the cycle after the item leaves the two-entry
// queue. After reset the data memory is swept to zero, one word a cycle,
// over all MEM_DEPTH words (256 by default); no item is taken in the sweep.
// A stall on m fills the queue and then drops s_tready.
`default_nettype none

module toy_isa_instruction_executor_core #(
	parameter int MEM_DEPTH  = tie_pkg::MEM_DEPTH_DEF,
	parameter int DATA_WIDTH = tie_pkg::DATA_WIDTH_DEF,
	parameter int PC_WIDTH   = tie_pkg::PC_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// [1:0] command
	input  wire logic [tie_pkg::S_USER_W-1:0]  s_tuser,
	// [15:0] instruction, [23:16] mem_address, [55:24] write_data
	input  wire logic [tie_pkg::S_DATA_W-1:0]  s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [15:0] next_pc, [16] halted, [17] branch_taken, [49:18] read_data,
	// [50] bad_address, [55:51] zero
	output logic [tie_pkg::M_DATA_W-1:0]       m_tdata
);

	logic             q_valid;
	tie_pkg::item_t   q_item;
	logic             q_pop;
	logic             clearing;
	tie_pkg::result_t res;

	tie_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.clearing (clearing),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	tie_back #(
		.MEM_DEPTH  (MEM_DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.PC_WIDTH   (PC_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.clearing (clearing),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res)
	);

	// Pack the result item
	assign m_tdata = {5'd0, res.bad_address, res.read_data, res.branch_taken,
		res.halted, res.next_pc};

`ifndef SYNTHESIS
	// No item is taken while the memory is being cleared
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !s_tready)
		else $error("item accepted during memory clearing");

	// A taken branch never comes from a halted core
	a_taken_not_halted: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[tie_pkg::M_TAKEN_BIT]) |-> !m_tdata[tie_pkg::M_HALT_BIT])
		else $error("branch taken while halted");

	// A flagged address never returns data
	a_bad_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[tie_pkg::M_BAD_BIT]) |->
			(m_tdata[tie_pkg::M_BAD_BIT-1:tie_pkg::M_RDATA_LSB] == 32'd0))
		else $error("read data on bad address");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the toy ISA instruction executor core.
`timescale 1ns / 100ps

module tb_top;
	import tie_pkg::*;

	localparam int MEM_WORDS      = MEM_DEPTH_DEF;
	localparam int RANDOM_ITEMS   = 550;
	localparam int CALM_ITEMS     = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 20;

	// Predicts each result from its own copy of pc, registers, memory and halt flag
	class exec_scoreboard;
		logic [15:0] pc;
		logic [31:0] regs [REG_COUNT];
		logic [31:0] mem [MEM_WORDS];
		bit          halt;
		result_t     pending_q [$];
		int          errors;

		function new();
			pc = '0;
			halt = 1'b0;
			errors = 0;
			foreach (regs[i]) regs[i] = '0;
			foreach (mem[i]) mem[i] = '0;
		endfunction

		function int waiting();
			return pending_q.size();
		endfunction

		// Apply one accepted item and queue the result it must give
		function void note_input(cmd_t cmd, logic [15:0] ins, logic [7:0] maddr,
				logic [31:0] wdata);
			result_t     r;
			op_t         op;
			logic [3:0]  rd, rs, rt;
			logic [31:0] a, b;
			logic [15:0] npc;
			r = '0;
			op = op_t'(ins[15:13]);
			rd = ins[11:8];
			rs = ins[7:4];
			rt = ins[3:0];
			a = regs[rs];
			b = ins[12] ? {{28{ins[3]}}, ins[3:0]} : regs[rt];
			npc = pc + 16'd2;
			case (cmd)
				CMD_WRITE: begin
					if (maddr < MEM_WORDS)
						mem[maddr] = wdata;
					else
						r.bad_address = 1'b1;
				end
				CMD_READ: begin
					if (maddr < MEM_WORDS)
						r.read_data = mem[maddr];
					else
						r.bad_address = 1'b1;
				end
				CMD_EXEC: begin
					if (!halt) begin
						case (op)
							OP_ADD: regs[rd] = a + b;
							OP_SUB: regs[rd] = a - b;
							OP_MUL: regs[rd] = a * b;
							OP_LOAD: begin
								if (a < MEM_WORDS) begin
									regs[rd] = mem[a[7:0]];
								end else begin
									regs[rd] = '0;
									r.bad_address = 1'b1;
								end
							end
							OP_STORE: begin
								if (regs[rd] < MEM_WORDS)
									mem[regs[rd][7:0]] = a;
								else
									r.bad_address = 1'b1;
							end
							OP_JUMP: begin
								npc = pc + {{7{ins[11]}}, ins[11:4], 1'b0};
								r.branch_taken = 1'b1;
							end
							OP_BEQZ: begin
								if (regs[rd] == '0) begin
									npc = pc + {{7{ins[7]}}, ins[7:0], 1'b0};
									r.branch_taken = 1'b1;
								end
							end
							default: begin
								// system op: halt holds the pc, nop just steps
								if (!ins[12]) begin
									halt = 1'b1;
									npc = pc;
								end
							end
						endcase
						pc = npc;
					end
				end
				default: ;
			endcase
			r.next_pc = pc;
			r.halted = halt;
			pending_q = {pending_q, r};
		endfunction

		task report(string field, logic [31:0] want, logic [31:0] got);
			$display("MISMATCH %s: expected %h, got %h at %0t", field, want, got, $time);
			errors++;
		endtask

		// Compare one result with the oldest expectation
		task check_result(result_t got);
			result_t want;
			if (pending_q.size() == 0) begin
				report("unexpected result next_pc", '0, got.next_pc);
				return;
			end
			want = pending_q.pop_front();
			if (got.next_pc !== want.next_pc)
				report("next_pc", want.next_pc, got.next_pc);
			if (got.halted !== want.halted)
				report("halted", want.halted, got.halted);
			if (got.branch_taken !== want.branch_taken)
				report("branch_taken", want.branch_taken, got.branch_taken);
			if (got.read_data !== want.read_data)
				report("read_data", want.read_data, got.read_data);
			if (got.bad_address !== want.bad_address)
				report("bad_address", want.bad_address, got.bad_address);
		endtask
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_USER_W-1:0] s_tuser = '0;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	logic                no_idle = 1'b0;
	int                  stall_left = 0;
	int                  quiet_cycles = 0;
	int                  items_sent = 0;

	exec_scoreboard sb = new();

	toy_isa_instruction_executor_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Stall the result side in random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!no_idle && $urandom_range(0, 9) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 16);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(result_t'(m_tdata[50:0]));
	end

	// Abort when nothing moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [15:0] instr_word(op_t op, logic imm, logic [3:0] f1,
			logic [3:0] f2, logic [3:0] f3);
		return {op, imm, f1, f2, f3};
	endfunction

	// Any instruction but halt, which is kept for the closing part
	function automatic logic [15:0] rand_instr();
		logic [15:0] w;
		w = 16'($urandom);
		if (w[15:13] == OP_SYS)
			w[12] = 1'b1;
		return w;
	endfunction

	// Offer one item, with an optional idle burst first, and hold it until taken
	task automatic send_item(cmd_t cmd, logic [15:0] ins, logic [7:0] maddr,
			logic [31:0] wdata);
		if (!no_idle && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {wdata, maddr, ins};
		do @(posedge clk); while (!s_tready);
		sb.note_input(cmd, ins, maddr, wdata);
		items_sent++;
	endtask

	task automatic exec_item(logic [15:0] ins);
		send_item(CMD_EXEC, ins, 8'($urandom), $urandom);
	endtask

	task automatic mem_item(cmd_t cmd, logic [7:0] maddr, logic [31:0] wdata);
		send_item(cmd, 16'($urandom), maddr, wdata);
	endtask

	// Stop sending until every outstanding result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.waiting() != 0);
	endtask

	// Build an address in a register from a pointer table entry, then use it
	task automatic pointer_access();
		logic [3:0]  ra, rb;
		logic [2:0]  slot;
		logic [31:0] addr;
		ra = 4'($urandom);
		rb = 4'($urandom);
		slot = 3'($urandom);
		case ($urandom_range(0, 9))
			0: addr = $urandom;
			1: addr = MEM_WORDS + $urandom_range(0, 15);
			default: addr = $urandom_range(0, MEM_WORDS - 1);
		endcase
		mem_item(CMD_WRITE, {5'd0, slot}, addr);
		exec_item(instr_word(OP_SUB, 1'b0, ra, ra, ra));
		exec_item(instr_word(OP_ADD, 1'b1, ra, ra, {1'b0, slot}));
		exec_item(instr_word(OP_LOAD, 1'($urandom), ra, ra, 4'($urandom)));
		if ($urandom_range(0, 1) == 0)
			exec_item(instr_word(OP_STORE, 1'($urandom), ra, rb, 4'($urandom)));
		else
			exec_item(instr_word(OP_LOAD, 1'($urandom), rb, ra, 4'($urandom)));
		mem_item(CMD_READ, addr[7:0], $urandom);
	endtask

	initial begin
		bit pressured;
		int limit;
		pressured = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: memory extremes, every operation, range faults, branch extremes
		mem_item(CMD_READ, 8'd0, $urandom);
		mem_item(CMD_READ, 8'd255, $urandom);
		mem_item(CMD_WRITE, 8'd255, 32'h8000_0000);
		mem_item(CMD_WRITE, 8'd0, 32'h7FFF_FFFF);
		mem_item(CMD_READ, 8'd255, $urandom);
		send_item(CMD_IGNORE, 16'($urandom), 8'($urandom), $urandom);
		exec_item(instr_word(OP_ADD, 1'b1, 4'd1, 4'd0, 4'd7));
		exec_item(instr_word(OP_SUB, 1'b1, 4'd2, 4'd0, 4'd8));
		exec_item(instr_word(OP_MUL, 1'b0, 4'd3, 4'd1, 4'd2));
		exec_item(instr_word(OP_ADD, 1'b0, 4'd4, 4'd3, 4'd3));
		exec_item(instr_word(OP_SUB, 1'b0, 4'd5, 4'd0, 4'd1));
		exec_item(instr_word(OP_MUL, 1'b1, 4'd6, 4'd5, 4'hF));
		exec_item(instr_word(OP_STORE, 1'b0, 4'd1, 4'd3, 4'd0));
		exec_item(instr_word(OP_LOAD, 1'b0, 4'd7, 4'd1, 4'd0));
		exec_item(instr_word(OP_LOAD, 1'b1, 4'd8, 4'd5, 4'd0));
		exec_item(instr_word(OP_STORE, 1'b1, 4'd5, 4'd1, 4'd0));
		mem_item(CMD_READ, 8'd7, $urandom);
		exec_item({OP_JUMP, 1'b0, 8'h7F, 4'h0});
		exec_item({OP_JUMP, 1'b1, 8'h80, 4'hF});
		exec_item({OP_BEQZ, 1'b0, 4'd8, 8'h7F});
		exec_item({OP_BEQZ, 1'b1, 4'd1, 8'h80});
		exec_item(instr_word(OP_SYS, 1'b1, 4'hF, 4'hF, 4'hF));
		exec_item(instr_word(OP_SUB, 1'b0, 4'd0, 4'd0, 4'd0));
		drain();

		// Random: mostly pointer sequences and plain instructions, some noise
		limit = items_sent + RANDOM_ITEMS;
		while (items_sent < limit) begin
			if (items_sent >= limit - CALM_ITEMS)
				no_idle <= 1'b1;
			if (!pressured && items_sent >= limit - RANDOM_ITEMS / 2) begin
				pressured = 1'b1;
				drain();
			end
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4: pointer_access();
				5: mem_item(CMD_WRITE, 8'($urandom), $urandom);
				6: mem_item(CMD_READ, 8'($urandom), $urandom);
				7: send_item(CMD_IGNORE, 16'($urandom), 8'($urandom), $urandom);
				8: begin
					logic [3:0] rz;
					rz = 4'($urandom);
					exec_item(instr_word(OP_SUB, 1'b0, rz, rz, rz));
					exec_item({OP_BEQZ, 1'b0, rz, 8'($urandom)} | {3'b0, 1'($urandom), 12'h0});
				end
				default: exec_item(rand_instr());
			endcase
		end

		// Halt, then check that execution stops while memory commands still run
		exec_item(instr_word(OP_SYS, 1'b0, 4'($urandom), 4'($urandom), 4'($urandom)));
		exec_item(instr_word(OP_ADD, 1'b1, 4'd0, 4'd0, 4'd1));
		exec_item({OP_JUMP, 1'b0, 8'h10, 4'h0});
		exec_item(instr_word(OP_STORE, 1'b0, 4'd0, 4'd1, 4'd0));
		exec_item(instr_word(OP_SYS, 1'b0, 4'hF, 4'hF, 4'hF));
		mem_item(CMD_WRITE, 8'd3, 32'hDEAD_BEEF);
		mem_item(CMD_READ, 8'd3, $urandom);
		send_item(CMD_IGNORE, 16'($urandom), 8'($urandom), $urandom);
		exec_item(instr_word(OP_SYS, 1'b1, 4'd0, 4'd0, 4'd0));

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.waiting() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: files.f
sv/tie_pkg.sv
sv/tie_ram.sv
sv/tie_front.sv
sv/tie_back.sv
sv/toy_isa_instruction_executor_core.sv
tb/tb_top.sv
